// ===== rtl/connection_reuse_counter_macros.svh =====
// ----------------------------------------------------------------------------
// Connection reuse counter assertion macros
// Concurrent assertion shorthands used by the back end of the block.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_REUSE_COUNTER_MACROS_SVH
`define CONNECTION_REUSE_COUNTER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define CRC_ASSERT_NOW(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define CRC_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter package
// Shared types and constants of the front end, queue and back end.
// ----------------------------------------------------------------------------
package crc_pkg;

	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned TS_W        = 32;
	localparam int unsigned QCNT_W      = 32;
	localparam int unsigned CONN_W      = 7;
	localparam int unsigned RTT_W       = 32;
	localparam int unsigned PROD_W      = 42;

	localparam logic [PROD_W-1:0] MS_PER_SECOND = PROD_W'(1000);
	localparam logic [RTT_W-1:0]  RTT_RESET     = RTT_W'(50);
	localparam logic [CONN_W-1:0] CONN_CNT_MAX  = '1;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_FILL_W = $clog2(QUEUE_DEPTH + 1);

	// Work class decided by the front end.
	typedef enum logic [1:0] {
		CLS_FLUSH  = 2'd0, // report the open group and close it
		CLS_START  = 2'd1, // open a group, no group was open
		CLS_SWITCH = 2'd2, // report the open group and open a new one
		CLS_REUSE  = 2'd3  // query of the open group, scan the pool
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [ADDR_W-1:0] addr;
		logic [TS_W-1:0]   ts;
	} item_t;

endpackage

// ===== rtl/crc_ram.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter RAM
// Simple dual-port memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module crc_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/crc_queue.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module crc_queue
	import crc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  q_valid,
	output item_t q_item
);

	item_t                  entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q;
	logic [QPTR_W-1:0]      rd_ptr_q;
	logic [QCNT_FILL_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full    = (count_q == QCNT_FILL_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_FILL_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_FILL_W'(1);
			end
		end
	end

endmodule

// ===== rtl/crc_front.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter front end
// Accepts input beats, tracks the open group and classifies each beat.
// ----------------------------------------------------------------------------
module crc_front
	import crc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [ADDR_W-1:0] source_addr,
	input  logic [TS_W-1:0]   timestamp,
	output logic              push,
	output item_t             push_item,
	input  logic              full
);

	logic              open_q;
	logic [ADDR_W-1:0] addr_q;
	logic              accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	always_comb begin
		push_item.addr = source_addr;
		push_item.ts   = timestamp;
		if (action) begin
			push_item.cls = CLS_FLUSH;
		end else if (!open_q) begin
			push_item.cls = CLS_START;
		end else if (source_addr != addr_q) begin
			push_item.cls = CLS_SWITCH;
		end else begin
			push_item.cls = CLS_REUSE;
		end
	end

	// A flush with no open group does nothing: drop it here.
	assign push = accept && !(action && !open_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			addr_q <= '0;
		end else if (accept) begin
			if (action) begin
				open_q <= 1'b0;
			end else begin
				open_q <= 1'b1;
				addr_q <= source_addr;
			end
		end
	end

endmodule

// ===== rtl/crc_back.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter back end
// Runs group bookkeeping and the first-fit slot scan, drives the result beat.
// ----------------------------------------------------------------------------
`include "connection_reuse_counter_macros.svh"

module crc_back
	import crc_pkg::*;
#(
	parameter int unsigned POOL_SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RTT_W-1:0]  rtt_ms,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] group_source,
	output logic [CONN_W-1:0] connection_count,
	output logic [QCNT_W-1:0] query_total,
	output logic              pool_overflow
);

	localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(POOL_SLOTS + 1);
	localparam int unsigned EXT_W = (CNT_W > CONN_W) ? CNT_W : CONN_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_CMP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TS_W-1:0]   ts_q;
	logic [TS_W-1:0]   elapsed_q;
	logic [ADDR_W-1:0] addr_q;
	logic [QCNT_W-1:0] queries_q;
	logic              ovf_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_source_q;
	logic [CONN_W-1:0] out_conn_q;
	logic [QCNT_W-1:0] out_queries_q;
	logic              out_ovf_q;

	logic              out_free;
	logic              emit;
	logic              hit;
	logic              more;
	logic              room;
	logic [PROD_W-1:0] elapsed_ms;
	logic [EXT_W-1:0]  cnt_ext;
	logic [CONN_W-1:0] conn_sat;
	logic [CNT_W:0]    idx_ext;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [TS_W-1:0]   ram_wdata;
	logic              ram_re;
	logic [TS_W-1:0]   ram_rdata;

	crc_ram #(
		.WIDTH (TS_W),
		.DEPTH (POOL_SLOTS),
		.ADDR_W(IDX_W)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign out_free   = !out_valid_q || !out_stall;
	assign elapsed_ms = PROD_W'(elapsed_q) * MS_PER_SECOND;
	assign hit        = elapsed_ms > PROD_W'(rtt_ms);
	assign idx_ext    = (CNT_W + 1)'(idx_q);
	assign more       = (idx_ext + (CNT_W + 1)'(1)) < (CNT_W + 1)'(cnt_q);
	assign room       = cnt_q < CNT_FULL;
	assign cnt_ext    = EXT_W'(cnt_q);
	assign conn_sat   = (cnt_ext > EXT_W'(CONN_CNT_MAX)) ? CONN_CNT_MAX : cnt_ext[CONN_W-1:0];

	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ts_q;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.cls)
						CLS_FLUSH: begin
							emit = out_free;
							pop  = out_free;
						end
						CLS_START: begin
							pop       = 1'b1;
							ram_we    = 1'b1;
							ram_waddr = '0;
							ram_wdata = q_item.ts;
						end
						CLS_SWITCH: begin
							emit      = out_free;
							pop       = out_free;
							ram_we    = out_free;
							ram_waddr = '0;
							ram_wdata = q_item.ts;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_DIFF: begin
			end
			ST_CMP: begin
				if (hit) begin
					ram_we = 1'b1;
				end else if (!more && room) begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			idx_q         <= '0;
			ts_q          <= '0;
			elapsed_q     <= '0;
			addr_q        <= '0;
			queries_q     <= '0;
			ovf_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			out_source_q  <= '0;
			out_conn_q    <= '0;
			out_queries_q <= '0;
			out_ovf_q     <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q   <= 1'b1;
				out_source_q  <= addr_q;
				out_conn_q    <= conn_sat;
				out_queries_q <= queries_q;
				out_ovf_q     <= ovf_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (q_item.cls)
							CLS_START, CLS_SWITCH: begin
								addr_q    <= q_item.addr;
								cnt_q     <= CNT_W'(1);
								queries_q <= QCNT_W'(1);
								ovf_q     <= 1'b0;
							end
							CLS_REUSE: begin
								ts_q    <= q_item.ts;
								idx_q   <= '0;
								state_q <= ST_READ;
								if (queries_q != '1) begin
									queries_q <= queries_q + QCNT_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					elapsed_q <= ts_q - ram_rdata;
					state_q   <= ST_CMP;
				end
				ST_CMP: begin
					if (hit) begin
						state_q <= ST_IDLE;
					end else if (more) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_READ;
					end else begin
						if (room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign group_source     = out_source_q;
	assign connection_count = out_conn_q;
	assign query_total      = out_queries_q;
	assign pool_overflow    = out_ovf_q;

	`CRC_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_FULL, "slot count beyond pool size")
	`CRC_ASSERT_NOW(a_scan_idx, clk, arst_n, state_q != ST_IDLE, idx_ext < (CNT_W + 1)'(cnt_q), "scan index past open slots")
	`CRC_ASSERT_NEXT(a_reuse_scan, clk, arst_n, pop && (q_item.cls == CLS_REUSE), state_q == ST_READ, "reuse query did not start a scan")

endmodule

// ===== rtl/connection_reuse_counter.sv =====
// ----------------------------------------------------------------------------
// Connection reuse counter
// Groups queries by source and counts the pool connections each group opens.
// ----------------------------------------------------------------------------
// Each input beat is a query (action 0) or a flush (action 1). Queries from
// one source form a group; a query from a different source or a flush reports
// the open group on the output channel (source, opened slots saturating at
// 127, query count saturating at 2^32-1, pool overflow flag). Inside a group a
// query reuses the first slot, in slot order, whose last use lies more than
// rtt_ms milliseconds back, else opens a new slot. The front end accepts one
// beat per cycle while its two-entry queue has room and classifies it from a
// copy of the open-group state; a flush with no open group is dropped there.
// The back end handles a group start, a group switch or a flush in its idle
// state; a repeat query scans the open slots in order up to the reused slot,
// or through all of them when none fits, each slot going through the read,
// subtract and multiply-compare steps of the slot memory's single read port.
// The result sits in an output register, so the back end keeps working while
// a report waits, holding only when it must report again. rtt_ms sits at
// byte address 0 of the configuration port and resets to 50; slot memory
// needs no clearing.
// ----------------------------------------------------------------------------
module connection_reuse_counter
	import crc_pkg::*;
#(
	parameter int unsigned POOL_SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [ADDR_W-1:0] source_addr,
	input  logic [TS_W-1:0]   timestamp,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] group_source,
	output logic [CONN_W-1:0] connection_count,
	output logic [QCNT_W-1:0] query_total,
	output logic              pool_overflow
);

	// Register word select: paddr[2] picks the word, rtt_ms is word 0.
	localparam logic REG_RTT_MS = 1'b0;

	logic [RTT_W-1:0] rtt_q;
	logic             cfg_write;

	logic  push;
	item_t push_item;
	logic  full;
	logic  pop;
	logic  q_valid;
	item_t q_item;

	// Write on the access phase; pready is tied high so no access has wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RTT_MS);
	assign prdata    = (paddr[2] == REG_RTT_MS) ? rtt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtt_q <= RTT_RESET;
		end else if (cfg_write) begin
			rtt_q <= pwdata;
		end
	end

	// Classify beats against the open group and queue them.
	crc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.source_addr(source_addr),
		.timestamp  (timestamp),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	// Decouple the front, one beat per cycle while the queue has room, from the slot scan.
	crc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	// Run the slot pool and drive the report beat.
	crc_back #(
		.POOL_SLOTS(POOL_SLOTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rtt_ms          (rtt_q),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.group_source    (group_source),
		.connection_count(connection_count),
		.query_total     (query_total),
		.pool_overflow   (pool_overflow)
	);

endmodule

// ===== verif/tb_connection_reuse_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connection reuse counter testbench
// Drives query and flush beats with random idle and stall bursts, programs
// rtt_ms over the register port, and checks every group report against a
// cycle-free prediction of the slot pool kept inside the bench.
// ----------------------------------------------------------------------------
module tb_connection_reuse_counter;
	import crc_pkg::*;

	localparam int unsigned POOL_SLOTS    = 64;
	localparam logic [2:0]  RTT_REG_ADDR  = 3'd0;
	localparam logic        ACT_QUERY     = 1'b0;
	localparam logic        ACT_FLUSH     = 1'b1;
	// Covers a full queue of worst-case pool scans still running when the last
	// report has come out.
	localparam int unsigned SETTLE_CYCLES = 800;
	localparam int unsigned PHASE_BEATS   = 165;
	localparam int unsigned PHASES        = 6;

	typedef struct {
		logic              act;
		logic [ADDR_W-1:0] addr;
		logic [TS_W-1:0]   ts;
	} beat_t;

	typedef struct {
		logic [ADDR_W-1:0] src;
		logic [CONN_W-1:0] conns;
		logic [QCNT_W-1:0] queries;
		logic              ovf;
	} report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = 1'b0;
	logic [ADDR_W-1:0] source_addr = '0;
	logic [TS_W-1:0]   timestamp = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] group_source;
	logic [CONN_W-1:0] connection_count;
	logic [QCNT_W-1:0] query_total;
	logic              pool_overflow;

	connection_reuse_counter #(.POOL_SLOTS(POOL_SLOTS)) dut (.*);

	// Beats waiting to be driven, and group reports still owed by the block.
	beat_t   query_q [$];
	report_t expected_reports [$];

	int unsigned errors = 0;
	// Idle and stall odds: one cycle in idle_div starts a burst; zero turns both off.
	int unsigned idle_div = 8;
	bit          in_live = 1'b0;
	bit          in_took = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;

	// Shadow of the pool and the open group.
	logic [TS_W-1:0]   slot_stamp [POOL_SLOTS];
	int unsigned       open_slots = 0;
	bit                grp_live = 1'b0;
	logic [ADDR_W-1:0] grp_src = '0;
	logic [QCNT_W-1:0] grp_queries = '0;
	bit                grp_ovf = 1'b0;
	logic [RTT_W-1:0]  rtt_model = RTT_RESET;

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#6_000_000;
		$display("FAILURE");
		$finish;
	end

	// Queue the report for the group that is closing now.
	function automatic void push_report();
		report_t r;
		r.src     = grp_src;
		r.conns   = (open_slots > CONN_CNT_MAX) ? CONN_CNT_MAX : CONN_W'(open_slots);
		r.queries = grp_queries;
		r.ovf     = grp_ovf;
		expected_reports.insert(expected_reports.size(), r);
	endfunction

	// Advance the shadow state by one accepted beat.
	function automatic void account_beat(input beat_t b);
		logic [TS_W-1:0]   elapsed;
		logic [PROD_W-1:0] ms;
		bit                reused;
		int unsigned       i;
		reused = 1'b0;
		if (b.act == ACT_FLUSH) begin
			// A flush with nothing open is dropped without a report.
			if (grp_live) begin
				push_report();
				grp_live = 1'b0;
			end
		end else if (!grp_live || b.addr != grp_src) begin
			// A new source closes the open group and starts over at slot 0.
			if (grp_live)
				push_report();
			grp_live      = 1'b1;
			grp_src       = b.addr;
			grp_queries   = 1;
			grp_ovf       = 1'b0;
			slot_stamp[0] = b.ts;
			open_slots    = 1;
		end else begin
			// First fit: elapsed wraps when time runs backward, the product is
			// exact in 42 bits.
			for (i = 0; i < open_slots; i++) begin
				elapsed = b.ts - slot_stamp[i];
				ms = PROD_W'(elapsed) * MS_PER_SECOND;
				if (ms > PROD_W'(rtt_model)) begin
					slot_stamp[i] = b.ts;
					reused = 1'b1;
					break;
				end
			end
			if (!reused) begin
				if (open_slots < POOL_SLOTS) begin
					slot_stamp[open_slots] = b.ts;
					open_slots++;
				end else begin
					grp_ovf = 1'b1;
				end
			end
			if (grp_queries != '1)
				grp_queries++;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic void push_beat(input logic act, input logic [ADDR_W-1:0] addr,
			input logic [TS_W-1:0] ts);
		beat_t b;
		b.act  = act;
		b.addr = addr;
		b.ts   = ts;
		query_q.insert(query_q.size(), b);
	endfunction

	// Input driver: hold a beat until it is taken, then fetch the next one or
	// idle for a burst. Valid never looks at stall.
	always @(negedge clk) begin
		beat_t cur;
		if (in_took) begin
			in_live = 1'b0;
			in_took = 1'b0;
		end
		if (arst_n && !in_live) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (idle_div != 0 && $urandom_range(0, idle_div - 1) == 0) begin
				send_gap = $urandom_range(0, 17);
			end else if (query_q.size() > 0) begin
				cur = query_q.pop_front();
				action      <= cur.act;
				source_addr <= cur.addr;
				timestamp   <= cur.ts;
				in_live = 1'b1;
			end
		end
		in_valid <= in_live;
	end

	// Output side back-pressure in bursts.
	always @(negedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_div != 0 && $urandom_range(0, idle_div - 1) == 0)
			stall_left = $urandom_range(1, 18);
		out_stall <= (stall_left > 0);
	end

	// Monitor: predict on every input beat, check every output beat.
	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				account_beat('{action, source_addr, timestamp});
				in_took = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, expected none, got src %0h conns %0d queries %0d ovf %0b",
						$time, group_source, connection_count, query_total, pool_overflow);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					check_field("group_source", want.src, group_source);
					check_field("connection_count", want.conns, connection_count);
					check_field("query_total", want.queries, query_total);
					check_field("pool_overflow", want.ovf, pool_overflow);
				end
			end
		end
	end

	// Read rtt_ms back and compare.
	task automatic check_rtt(input logic [RTT_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= RTT_REG_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$display("%0t: rtt_ms readback mismatch, expected %0h, got %0h", $time, want, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_rtt(input logic [RTT_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RTT_REG_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rtt_model = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_rtt(value);
	endtask

	// Drain everything queued, wait for the owed reports, then let any
	// report-free work inside the block finish.
	task automatic settle();
		while (query_q.size() != 0 || in_live)
			@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [ADDR_W-1:0] hosts [4];
		logic [ADDR_W-1:0] src;
		logic [TS_W-1:0]   ts;
		logic [RTT_W-1:0]  rtt_pick;
		int unsigned       sent;
		int unsigned       len;
		int unsigned       kind;
		int unsigned       phase;
		int unsigned       h;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_rtt(RTT_RESET);

		// Directed, rtt_ms at its reset value of 50.
		push_beat(ACT_FLUSH, '0, '0);                      // flush with nothing open
		push_beat(ACT_QUERY, '0, '0);                      // group start
		push_beat(ACT_QUERY, '0, '0);                      // same second: new slot
		push_beat(ACT_QUERY, '0, 32'd1);                   // one second: reuse slot 0
		push_beat(ACT_QUERY, '0, '0);                      // time backward: wraps, reuse
		push_beat(ACT_FLUSH, '1, '1);                      // report and close
		push_beat(ACT_FLUSH, '0, '0);                      // nothing left to close
		push_beat(ACT_QUERY, '1, '1);
		push_beat(ACT_QUERY, '1, '0);                      // forward across the wrap
		push_beat(ACT_QUERY, 32'hA5A5_A5A5, 32'h5A5A_5A5A); // source switch
		push_beat(ACT_QUERY, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		push_beat(ACT_QUERY, 32'h5A5A_5A5A, 32'hA5A5_A5A5); // switch again
		push_beat(ACT_FLUSH, '0, '0);
		settle();

		// Zero rtt: any whole second qualifies, the same second does not.
		write_rtt('0);
		push_beat(ACT_QUERY, 32'h0000_0100, 32'd100);
		push_beat(ACT_QUERY, 32'h0000_0100, 32'd100);
		push_beat(ACT_QUERY, 32'h0000_0100, 32'd101);
		push_beat(ACT_FLUSH, '0, '0);
		settle();

		// Largest rtt: only a product past 2^32-1 qualifies.
		write_rtt('1);
		push_beat(ACT_QUERY, 32'h0000_0200, 32'h8000_0000);
		push_beat(ACT_QUERY, 32'h0000_0200, 32'h8000_0000 + 32'd4294967);
		push_beat(ACT_QUERY, 32'h0000_0200, 32'h8000_0000 + 32'd4294968);
		push_beat(ACT_FLUSH, '0, '0);

		// Random phases, each under its own rtt; the last one runs without idling.
		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: rtt_pick = RTT_RESET;
				1: rtt_pick = '0;
				2: rtt_pick = '1;
				3: rtt_pick = 32'd1000;
				4: rtt_pick = 32'd2999;
				default: rtt_pick = $urandom();
			endcase
			write_rtt(rtt_pick);
			case ($urandom_range(0, 2))
				0: idle_div = 3;
				1: idle_div = 8;
				default: idle_div = 30;
			endcase
			if (phase == PHASES - 1)
				idle_div = 0;
			for (h = 0; h < 4; h++)
				hosts[h] = $urandom();
			sent = 0;
			while (sent < PHASE_BEATS) begin
				kind = $urandom_range(0, 29);
				if (kind == 0) begin
					// Flood one group in a single second; floods longer than the pool overflow it.
					src = $urandom();
					ts  = $urandom();
					len = $urandom_range(60, 70);
					repeat (len) push_beat(ACT_QUERY, src, ts);
					push_beat(ACT_FLUSH, $urandom(), $urandom());
					sent += len + 1;
				end else if (kind < 4) begin
					// Noise beat: any action, any source, any time.
					push_beat(1'($urandom_range(0, 1)), ($urandom_range(0, 1) == 0) ?
						hosts[$urandom_range(0, 3)] : $urandom(), $urandom());
					sent++;
				end else begin
					// Well-formed group: small time steps, now and then a step back.
					src = ($urandom_range(0, 3) == 0) ? $urandom() : hosts[$urandom_range(0, 3)];
					ts  = $urandom();
					len = $urandom_range(1, 12);
					repeat (len) begin
						if ($urandom_range(0, 15) == 0)
							ts -= $urandom_range(1, 5);
						else
							ts += $urandom_range(0, 3);
						push_beat(ACT_QUERY, src, ts);
					end
					sent += len;
					if ($urandom_range(0, 2) == 0) begin
						push_beat(ACT_FLUSH, $urandom(), $urandom());
						sent++;
						if ($urandom_range(0, 4) == 0) begin
							push_beat(ACT_FLUSH, $urandom(), $urandom());
							sent++;
						end
					end
				end
			end
		end
		settle();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/crc_pkg.sv
rtl/crc_ram.sv
rtl/crc_queue.sv
rtl/crc_front.sv
rtl/crc_back.sv
rtl/connection_reuse_counter.sv
verif/tb_connection_reuse_counter.sv
